>>> rtl/core/hard_sphere_overlap_insert_macros.svh
// Assertion macros for the hard sphere overlap insert block.
// Included by the RTL file that checks its own logic; no other dependencies.
`ifndef HARD_SPHERE_OVERLAP_INSERT_MACROS_SVH
`define HARD_SPHERE_OVERLAP_INSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, off while reset is applied
`define HSOI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define HSOI_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define HSOI_ASSERT(label, prop, msg)
`define HSOI_ASSERT_NR(label, prop, msg)

`endif

`endif

>>> rtl/core/hsoi_pkg.sv
// Package for the hard sphere overlap insert block: widths, codes, item types
// and the per-axis minimum-image wrap. No dependencies.
`timescale 1ns / 1ps

package hsoi_pkg;

    localparam int COORD_BITS   = 24;
    localparam int FRAC_BITS    = 12;
    localparam int CAPACITY_DEF = 1024;

    localparam int BOX_W      = 23;
    localparam int LIMIT_W    = 11;
    localparam int COUNT_W    = 11;
    localparam int CLASH_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam logic [BOX_W-1:0]   BOX_RESET   = BOX_W'(131072);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

    // wrapped difference: magnitude stays below 2^(max(coord, box) + 1)
    localparam int MAXW = (COORD_BITS > BOX_W) ? COORD_BITS : BOX_W;
    localparam int DW   = MAXW + 2;
    localparam int SQW  = 2 * DW;

    // 1.0 squared in the squared-distance format
    localparam logic [SQW-1:0] UNIT_SQ = SQW'(1) << (2 * FRAC_BITS);

    localparam logic CMD_TRIAL = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        STAT_ACCEPT = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_CLEAR  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                         command;
        logic signed [COORD_BITS-1:0] cand_x;
        logic signed [COORD_BITS-1:0] cand_y;
        logic signed [COORD_BITS-1:0] cand_z;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   placed_count;
        logic [CLASH_W-1:0]   clash_index;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_pos;

    // one minimum-image wrap: subtract box if 2d > box, then add box if 2d < -box
    function automatic logic signed [DW-1:0] wrap_axis(
        input logic signed [DW-1:0] d,
        input logic [BOX_W-1:0]     box
    );
        logic signed [DW+1:0] t;
        logic signed [DW+1:0] b;
        t = {{2{d[DW-1]}}, d};
        b = {{(DW + 2 - BOX_W){1'b0}}, box};
        if ((t <<< 1) > b) begin
            t = t - b;
        end
        if ((t <<< 1) < -b) begin
            t = t + b;
        end
        return t[DW-1:0];
    endfunction

endpackage

>>> rtl/core/hard_sphere_overlap_insert.sv
// Hard sphere overlap insert: position store in one synchronous RAM, scanned by a
// five-stage compare pipeline. Depends on hsoi_pkg and the assertion macro header.
//
//  channel   ports                                      handshake
//  -------   -----------------------------------------  ------------------------------
//  command   start, busy, i_item                        taken when start & !busy
//  result    o_result_valid, o_result                   one-cycle strobe, no backpressure
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index/data  taken when valid & ready
//
// Clear, full and a trial on an empty store answer one cycle after the item.
// A trial against the stored particles makes one RAM read per cycle through the
// read/diff/wrap/square/compare stages, then drains the pipeline and answers.
// A clash stops further reads and ends the scan early.
// The store needs no clearing pass; entries at or above the count are never compared.
// Reset (i_rst_n low, synchronous) empties the store and loads the register defaults.
// The result strobe cannot be held off; busy stays high until the trial answers.
`timescale 1ns / 1ps
`include "hard_sphere_overlap_insert_macros.svh"

module hard_sphere_overlap_insert #(
    parameter int CAPACITY = hsoi_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  hsoi_pkg::t_in_item                  i_item,
    output logic                                o_result_valid,
    output hsoi_pkg::t_out_item                 o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hsoi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hsoi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int LCW = CW + hsoi_pkg::LIMIT_W;
    localparam int DW  = hsoi_pkg::DW;
    localparam int SQW = hsoi_pkg::SQW;
    localparam int CB  = hsoi_pkg::COORD_BITS;
    localparam int NST = 4;

    // state and registers
    hsoi_pkg::t_state             r_state, n_state;
    logic [hsoi_pkg::BOX_W-1:0]   r_box;
    logic [hsoi_pkg::LIMIT_W-1:0] r_limit;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_issue;
    logic                         r_found;
    logic [AW-1:0]                r_clash;
    hsoi_pkg::t_pos               r_cand;
    logic [NST-1:0]               r_pv;
    logic [AW-1:0]                r_tag [NST];
    logic                         r_out_valid;
    hsoi_pkg::t_out_item          r_out;

    hsoi_pkg::t_pos               r_mem [CAPACITY];
    hsoi_pkg::t_pos               r_rd_data;

    logic signed [DW-1:0]         r_dx, r_dy, r_dz;
    logic signed [DW-1:0]         r_wx, r_wy, r_wz;
    logic [SQW-1:0]               r_sqx, r_sqy, r_sqz;

    // control decode
    logic                         accept;
    logic                         issue;
    logic                         mem_we;
    logic                         count_clr;
    logic                         count_inc;
    logic                         at_limit;
    logic                         near;
    logic [CW-1:0]                count_next;
    hsoi_pkg::t_pos               wr_data;
    logic                         n_out_valid;
    hsoi_pkg::t_out_item          n_out;

    logic [LCW-1:0]               cnt_cmp, lim_cmp, cap_cmp, lim_eff;
    logic [CW+hsoi_pkg::COUNT_W-1:0] cnt_ext;
    logic [AW+hsoi_pkg::CLASH_W-1:0] clash_ext;
    logic signed [SQW-1:0]        sqx, sqy, sqz;
    logic [SQW-1:0]               dist_sq;

    assign busy        = (r_state != hsoi_pkg::ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // limit capped at the store depth
    assign cnt_cmp  = {{hsoi_pkg::LIMIT_W{1'b0}}, r_count};
    assign lim_cmp  = {{CW{1'b0}}, r_limit};
    assign cap_cmp  = LCW'(CAPACITY);
    assign lim_eff  = (lim_cmp > cap_cmp) ? cap_cmp : lim_cmp;
    assign at_limit = (cnt_cmp >= lim_eff);

    assign count_next = count_clr ? '0 : (count_inc ? r_count + CW'(1) : r_count);
    assign cnt_ext    = {{hsoi_pkg::COUNT_W{1'b0}}, count_next};
    assign clash_ext  = {{hsoi_pkg::CLASH_W{1'b0}}, r_clash};

    assign wr_data = (r_state == hsoi_pkg::ST_IDLE)
                   ? hsoi_pkg::t_pos'{z: i_item.cand_z, y: i_item.cand_y, x: i_item.cand_x}
                   : r_cand;

    // compare stage
    assign dist_sq = r_sqx + r_sqy + r_sqz;
    assign near    = (dist_sq < hsoi_pkg::UNIT_SQ);

    assign sqx = r_wx * r_wx;
    assign sqy = r_wy * r_wy;
    assign sqz = r_wz * r_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsoi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        issue       = 1'b0;
        mem_we      = 1'b0;
        count_clr   = 1'b0;
        count_inc   = 1'b0;
        n_out_valid = 1'b0;
        n_out       = '0;
        case (r_state)
            hsoi_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_item.command == hsoi_pkg::CMD_CLEAR) begin
                        count_clr          = 1'b1;
                        n_out_valid        = 1'b1;
                        n_out.status       = hsoi_pkg::STAT_CLEAR;
                    end else if (at_limit) begin
                        n_out_valid        = 1'b1;
                        n_out.status       = hsoi_pkg::STAT_FULL;
                        n_out.placed_count = cnt_ext[hsoi_pkg::COUNT_W-1:0];
                    end else if (r_count == '0) begin
                        // empty store: nothing to test against
                        mem_we             = 1'b1;
                        count_inc          = 1'b1;
                        n_out_valid        = 1'b1;
                        n_out.status       = hsoi_pkg::STAT_ACCEPT;
                        n_out.placed_count = cnt_ext[hsoi_pkg::COUNT_W-1:0];
                    end else begin
                        n_state = hsoi_pkg::ST_SCAN;
                    end
                end
            end
            hsoi_pkg::ST_SCAN: begin
                issue = (r_issue != r_count) && !r_found;
                if (r_found || ((r_issue == r_count) && (r_pv == '0))) begin
                    n_state = hsoi_pkg::ST_DONE;
                end
            end
            hsoi_pkg::ST_DONE: begin
                n_state     = hsoi_pkg::ST_IDLE;
                n_out_valid = 1'b1;
                if (r_found) begin
                    n_out.status       = hsoi_pkg::STAT_REJECT;
                    n_out.placed_count = cnt_ext[hsoi_pkg::COUNT_W-1:0];
                    n_out.clash_index  = clash_ext[hsoi_pkg::CLASH_W-1:0];
                end else begin
                    mem_we             = 1'b1;
                    count_inc          = 1'b1;
                    n_out.status       = hsoi_pkg::STAT_ACCEPT;
                    n_out.placed_count = cnt_ext[hsoi_pkg::COUNT_W-1:0];
                end
            end
            default: begin
                n_state = hsoi_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box   <= hsoi_pkg::BOX_RESET;
            r_limit <= hsoi_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hsoi_pkg::CFG_BOX:   r_box   <= i_cfg_data[hsoi_pkg::BOX_W-1:0];
                hsoi_pkg::CFG_LIMIT: r_limit <= i_cfg_data[hsoi_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // count, scan control, first-clash capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_issue     <= '0;
            r_found     <= 1'b0;
            r_pv        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= count_next;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_issue <= '0;
                r_found <= 1'b0;
                r_pv    <= '0;
            end else begin
                r_pv <= {r_pv[NST-2:0], issue};
                if (issue) begin
                    r_issue <= r_issue + CW'(1);
                end
                if ((r_state == hsoi_pkg::ST_SCAN) && r_pv[NST-1] && near && !r_found) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cand <= '{z: i_item.cand_z, y: i_item.cand_y, x: i_item.cand_x};
        end
        if ((r_state == hsoi_pkg::ST_SCAN) && r_pv[NST-1] && near && !r_found) begin
            r_clash <= r_tag[NST-1];
        end
        r_tag[0] <= r_issue[AW-1:0];
        for (int s = 1; s < NST; s++) begin
            r_tag[s] <= r_tag[s-1];
        end
        r_out <= n_out;
    end

    // position store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AW-1:0]] <= wr_data;
        end
        r_rd_data <= r_mem[r_issue[AW-1:0]];
    end

    // difference, wrap, square
    always_ff @(posedge i_clk) begin
        r_dx  <= {{(DW - CB){r_cand.x[CB-1]}}, r_cand.x}
               - {{(DW - CB){r_rd_data.x[CB-1]}}, r_rd_data.x};
        r_dy  <= {{(DW - CB){r_cand.y[CB-1]}}, r_cand.y}
               - {{(DW - CB){r_rd_data.y[CB-1]}}, r_rd_data.y};
        r_dz  <= {{(DW - CB){r_cand.z[CB-1]}}, r_cand.z}
               - {{(DW - CB){r_rd_data.z[CB-1]}}, r_rd_data.z};
        r_wx  <= hsoi_pkg::wrap_axis(r_dx, r_box);
        r_wy  <= hsoi_pkg::wrap_axis(r_dy, r_box);
        r_wz  <= hsoi_pkg::wrap_axis(r_dz, r_box);
        r_sqx <= sqx;
        r_sqy <= sqy;
        r_sqz <= sqz;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    `HSOI_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "stored count beyond capacity")
    `HSOI_ASSERT(a_issue_bound, (r_state == hsoi_pkg::ST_SCAN) |-> (r_issue <= r_count), "scan read past stored count")
    `HSOI_ASSERT(a_clash_stored, ((r_state == hsoi_pkg::ST_DONE) && r_found) |-> (r_clash < r_count), "clash index not a stored particle")
    `HSOI_ASSERT(a_item_answered, accept |=> (busy || r_out_valid), "accepted item neither busy nor answered")

endmodule

>>> tb/hard_sphere_overlap_insert_test.sv
// Self-checking bench for hard_sphere_overlap_insert: directed and random trials,
// clears and register settings. Predicts every result with its own model of the
// store. Depends on hsoi_pkg and the block's RTL.
`timescale 1ns / 1ps

module hard_sphere_overlap_insert_test;
    import hsoi_pkg::*;

    localparam int     ONE_Q12         = 1 << FRAC_BITS;
    localparam longint ONE_SQ_Q24      = 64'sd1 << (2 * FRAC_BITS);
    localparam int     ITEMS_PER_PHASE = 60;
    localparam int     RANDOM_PHASES   = 8;
    localparam int     MAX_REPORTS     = 10;

    class insert_scoreboard;
        t_pos        placed[CAPACITY_DEF];
        int unsigned n_placed;
        logic [BOX_W-1:0]   box;
        logic [LIMIT_W-1:0] limit;
        t_out_item   expected_outcomes[$];
        int unsigned failures;
        int unsigned items_taken;
        int unsigned outcome_tally[4];

        function new();
            box      = BOX_RESET;
            limit    = LIMIT_RESET;
            n_placed = 0;
            failures = 0;
            items_taken = 0;
            foreach (outcome_tally[k]) outcome_tally[k] = 0;
        endfunction

        function int unsigned pending();
            return expected_outcomes.size();
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_BOX) begin
                box = data[BOX_W-1:0];
            end else if (idx == CFG_LIMIT) begin
                limit = data[LIMIT_W-1:0];
            end
        endfunction

        // single minimum-image fold, no second wrap
        function longint fold(input longint d);
            longint b;
            b = longint'(box);
            if (2 * d > b) d = d - b;
            if (2 * d < -b) d = d + b;
            return d;
        endfunction

        function void note_item(input t_in_item it);
            t_out_item   res;
            int unsigned cap;
            longint      dx, dy, dz, r2;
            bit          hit;
            res = '0;
            items_taken++;
            if (it.command == CMD_CLEAR) begin
                n_placed   = 0;
                res.status = STAT_CLEAR;
            end else begin
                cap = (limit > CAPACITY_DEF) ? CAPACITY_DEF : limit;
                if (n_placed >= cap) begin
                    res.status = STAT_FULL;
                end else begin
                    hit = 1'b0;
                    for (int unsigned j = 0; j < n_placed; j++) begin
                        dx = fold(longint'(it.cand_x) - longint'(placed[j].x));
                        dy = fold(longint'(it.cand_y) - longint'(placed[j].y));
                        dz = fold(longint'(it.cand_z) - longint'(placed[j].z));
                        r2 = dx * dx + dy * dy + dz * dz;
                        if (r2 < ONE_SQ_Q24) begin
                            hit = 1'b1;
                            res.clash_index = CLASH_W'(j);
                            break;
                        end
                    end
                    if (hit) begin
                        res.status = STAT_REJECT;
                    end else begin
                        placed[n_placed].x = it.cand_x;
                        placed[n_placed].y = it.cand_y;
                        placed[n_placed].z = it.cand_z;
                        n_placed++;
                        res.status = STAT_ACCEPT;
                    end
                end
            end
            res.placed_count = COUNT_W'(n_placed);
            outcome_tally[res.status]++;
            expected_outcomes.push_back(res);
        endfunction

        function void log_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("%0t: %s: expected status %0d count %0d clash %0d, got status %0d count %0d clash %0d",
                         $time, what, want.status, want.placed_count, want.clash_index,
                         got.status, got.placed_count, got.clash_index);
            end
        endfunction

        function void check_result(input t_out_item got);
            t_out_item want;
            if (expected_outcomes.size() == 0) begin
                log_mismatch("result with no item outstanding", '0, got);
            end else begin
                want = expected_outcomes.pop_front();
                if (got.status !== want.status || got.placed_count !== want.placed_count ||
                    got.clash_index !== want.clash_index) begin
                    log_mismatch("result mismatch", want, got);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_in_item              i_item = '0;
    logic                  o_result_valid;
    t_out_item             o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    insert_scoreboard sb;
    bit               sender_gaps = 1'b1;
    int unsigned      settings_used = 0;

    hard_sphere_overlap_insert DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) sb.check_result(o_result);
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (start && !busy) sb.note_item(i_item);
        end
    end

    // start stays high after acceptance so back-to-back items need no re-raise
    task automatic send_item(input t_in_item it);
        if (sender_gaps && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic trial(input int x, input int y, input int z);
        t_in_item it;
        it.command = CMD_TRIAL;
        it.cand_x  = COORD_BITS'(x);
        it.cand_y  = COORD_BITS'(y);
        it.cand_z  = COORD_BITS'(z);
        send_item(it);
    endtask

    task automatic clear_store();
        t_in_item it;
        it.command = CMD_CLEAR;
        it.cand_x  = COORD_BITS'($urandom());
        it.cand_y  = COORD_BITS'($urandom());
        it.cand_z  = COORD_BITS'($urandom());
        send_item(it);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic [BOX_W-1:0] box, input int unsigned lim);
        settle();
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_BOX, CFG_DATA_W'(box));
            write_reg(CFG_LIMIT, CFG_DATA_W'(lim));
        end else begin
            write_reg(CFG_LIMIT, CFG_DATA_W'(lim));
            write_reg(CFG_BOX, CFG_DATA_W'(box));
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic signed [COORD_BITS-1:0] nudge(
        input logic signed [COORD_BITS-1:0] c
    );
        return COORD_BITS'(int'(c) + int'($urandom_range(0, 3 * ONE_Q12)) - 3 * ONE_Q12 / 2);
    endfunction

    // mostly in-box or near a stored particle; some full-range noise
    function automatic t_in_item random_trial(input logic [BOX_W-1:0] box);
        t_in_item    it;
        int unsigned pick;
        t_pos        base;
        int          half;
        it.command = CMD_TRIAL;
        pick = $urandom_range(0, 99);
        half = (box == 0) ? 16 * ONE_Q12 : int'(box / 2);
        if (pick < 12) begin
            it.cand_x = COORD_BITS'($urandom());
            it.cand_y = COORD_BITS'($urandom());
            it.cand_z = COORD_BITS'($urandom());
        end else if (pick < 45 && sb.n_placed != 0) begin
            base = sb.placed[$urandom_range(0, sb.n_placed - 1)];
            if ($urandom_range(0, 7) == 0) begin
                // exactly one diameter away along x
                it.cand_x = COORD_BITS'(int'(base.x)
                                        + ($urandom_range(0, 1) ? ONE_Q12 : -ONE_Q12));
                it.cand_y = base.y;
                it.cand_z = base.z;
            end else begin
                it.cand_x = nudge(base.x);
                it.cand_y = nudge(base.y);
                it.cand_z = nudge(base.z);
            end
        end else begin
            it.cand_x = COORD_BITS'(int'($urandom_range(0, 2 * half)) - half);
            it.cand_y = COORD_BITS'(int'($urandom_range(0, 2 * half)) - half);
            it.cand_z = COORD_BITS'(int'($urandom_range(0, 2 * half)) - half);
        end
        return it;
    endfunction

    initial begin
        logic [BOX_W-1:0] box;
        int unsigned      lim;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty store, exact-diameter boundary, wraps, extremes
        trial(0, 0, 0);
        trial(0, 0, 0);
        trial(ONE_Q12, 0, 0);
        trial(2 * ONE_Q12 - 1, 0, 0);
        trial(63 * ONE_Q12 / 4, 0, 0);
        trial(-63 * ONE_Q12 / 4, 0, 0);
        trial(0, 63 * ONE_Q12 / 4, 0);
        trial(0, -63 * ONE_Q12 / 4, 0);
        trial(0, 0, 63 * ONE_Q12 / 4);
        trial(0, 0, -63 * ONE_Q12 / 4);
        trial(8388607, 8388607, 8388607);
        trial(-8388608, -8388608, -8388608);
        trial(-8388608, 8388607, 0);

        // limit lowered below the count, then filled from empty
        configure(BOX_RESET, 2);
        trial(5 * ONE_Q12, 5 * ONE_Q12, 5 * ONE_Q12);
        clear_store();
        trial(0, 0, 0);
        trial(3 * ONE_Q12, 0, 0);
        trial(-3 * ONE_Q12, 0, 0);

        // zero box, then the largest box
        configure('0, 1024);
        trial(ONE_Q12, 0, 0);
        trial(ONE_Q12, 0, 0);
        configure('1, 1024);
        trial(8388607, -8388608, 8388607);
        trial(-8388608, 8388607, -8388608);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin box = BOX_RESET;           lim = 1024; end
                1: begin box = BOX_W'(4 * ONE_Q12);  lim = 1024; end
                2: begin box = BOX_W'(10 * ONE_Q12); lim = 7; end
                3: begin box = '0;                  lim = $urandom_range(1, 64); end
                4: begin box = '1;                  lim = 1024; end
                5: begin box = BOX_W'($urandom());  lim = 1; end
                6: begin
                    box = BOX_W'($urandom_range(2 * ONE_Q12, 20 * ONE_Q12));
                    lim = $urandom_range(1, 1024);
                end
                default: begin box = BOX_RESET; lim = $urandom_range(2, 40); end
            endcase
            configure(box, lim);
            sender_gaps = (ph != 0);
            if ($urandom_range(0, 1)) clear_store();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 5) begin
                    clear_store();
                end else begin
                    send_item(random_trial(box));
                end
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        $display("covered %0d items under %0d register settings", sb.items_taken,
                 settings_used);
        $display("outcomes: %0d placed, %0d overlaps, %0d full, %0d clears; %0d failures",
                 sb.outcome_tally[STAT_ACCEPT], sb.outcome_tally[STAT_REJECT],
                 sb.outcome_tally[STAT_FULL], sb.outcome_tally[STAT_CLEAR], sb.failures);
        if (sb.failures == 0) begin
            $display("hard_sphere_overlap_insert_test: done, clean");
        end else begin
            $display("hard_sphere_overlap_insert_test: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout waiting on the block");
        $display("hard_sphere_overlap_insert_test: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/hsoi_pkg.sv
rtl/core/hard_sphere_overlap_insert.sv
tb/hard_sphere_overlap_insert_test.sv
